// ===== hdl/dpp_pkg.sv =====
// Shared constants, register codes and fixed-point helpers for the depth pixel to point unit.
`default_nettype none

package dpp_pkg;

  localparam int DEF_IMAGE_WIDTH  = 320;
  localparam int DEF_IMAGE_HEIGHT = 240;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_VERT_FOCAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_CENTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_FOCAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL   = 3'd7;

  localparam logic [31:0] FOCAL_RESET = 32'd65536;

  localparam logic signed [31:0] LIM28 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE28 = 32'sh1000_0000;

  localparam int RAY_NW  = 62;
  localparam int RAY_DW  = 32;
  localparam int RAY_QW  = 31;
  localparam int OUT_NW  = 50;
  localparam int OUT_DW  = 33;
  localparam int OUT_QW  = 17;
  localparam int SQRT_RW = 32;

  localparam int MUL_STAGES = 15;
  localparam int LATENCY = 1 + (RAY_QW + 1) + 1 + MUL_STAGES + SQRT_RW + 2 + (OUT_QW + 1) + 1;

  localparam int DLY_AW = 7;

  function automatic logic signed [31:0] sat28(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return LIM28;
    end else if (v < -36'sd2147483647) begin
      return -LIM28;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] rs28(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] rnd;
    logic signed [35:0] sv;
    mag = p[63] ? 64'(-p) : 64'(p);
    rnd = (mag + 64'd134217728) >> 28;
    sv = p[63] ? -$signed({1'b0, rnd[34:0]}) : $signed({1'b0, rnd[34:0]});
    return sat28(sv);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dpp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/dpp_div.sv =====
// Pipelined restoring divider producing one quotient bit per stage, with overflow flag.
`default_nettype none

module dpp_div import dpp_pkg::*; #(
  parameter int NW = RAY_NW,
  parameter int DW = RAY_DW,
  parameter int QW = RAY_QW,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] n_in,
  input  wire logic [DW-1:0] d_in,
  input  wire logic [TW-1:0] tag_in,
  output logic      [QW-1:0] q_out,
  output logic               ovf_out,
  output logic      [TW-1:0] tag_out
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] d_ext;
  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] div_r [QW];
  logic [QW-1:0] lq_r  [QW+1];
  logic          ovf_r [QW+1];
  logic [TW-1:0] tag_r [QW+1];
  logic [DW:0]   st_w  [1:QW];

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] dd;
    t  = {rem, nb};
    dd = {1'b0, d};
    if (t >= dd) begin
      return {1'b1, DW'(t - dd)};
    end else begin
      return {1'b0, t[DW-1:0]};
    end
  endfunction

  assign hi_ext = CW'(n_in[NW-1:QW]);
  assign d_ext  = CW'(d_in);

  always_comb begin
    for (int i = 1; i <= QW; i++) begin
      st_w[i] = div_step(rem_r[i-1], lq_r[i-1][QW-1], div_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= hi_ext[DW-1:0];
    div_r[0] <= d_in;
    lq_r[0]  <= n_in[QW-1:0];
    ovf_r[0] <= hi_ext >= d_ext;
    tag_r[0] <= tag_in;
    for (int i = 1; i < QW; i++) begin
      rem_r[i] <= st_w[i][DW-1:0];
      div_r[i] <= div_r[i-1];
    end
    for (int i = 1; i <= QW; i++) begin
      lq_r[i]  <= {lq_r[i-1][QW-2:0], st_w[i][DW]};
      ovf_r[i] <= ovf_r[i-1];
      tag_r[i] <= tag_r[i-1];
    end
  end

  assign q_out   = lq_r[QW];
  assign ovf_out = ovf_r[QW];
  assign tag_out = tag_r[QW];

endmodule

`default_nettype wire

// ===== hdl/dpp_sqrt.sv =====
// Pipelined integer square root producing one root bit per stage.
`default_nettype none

module dpp_sqrt import dpp_pkg::*; #(
  parameter int RW = SQRT_RW
) (
  input  wire logic            clk,
  input  wire logic [2*RW-1:0] s_in,
  output logic      [RW-1:0]   root
);

  logic [RW+1:0]   rem_r  [RW-1];
  logic [2*RW-1:0] sh_r   [RW-1];
  logic [RW-1:0]   root_r [RW];
  logic [RW+2:0]   st_w   [RW];

  function automatic logic [RW+2:0] sq_step(input logic [RW+1:0] rem, input logic [1:0] pair,
                                            input logic [RW-1:0] rt);
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    t     = {rem, pair};
    trial = {2'b00, rt, 2'b01};
    if (t >= trial) begin
      return {1'b1, (RW+2)'(t - trial)};
    end else begin
      return {1'b0, t[RW+1:0]};
    end
  endfunction

  always_comb begin
    st_w[0] = sq_step('0, s_in[2*RW-1:2*RW-2], '0);
    for (int j = 1; j < RW; j++) begin
      st_w[j] = sq_step(rem_r[j-1], sh_r[j-1][2*RW-1:2*RW-2], root_r[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= st_w[0][RW+1:0];
    sh_r[0]   <= {s_in[2*RW-3:0], 2'b00};
    root_r[0] <= RW'(st_w[0][RW+2]);
    for (int j = 1; j < RW - 1; j++) begin
      rem_r[j] <= st_w[j][RW+1:0];
      sh_r[j]  <= {sh_r[j-1][2*RW-3:0], 2'b00};
    end
    for (int j = 1; j < RW; j++) begin
      root_r[j] <= {root_r[j-1][RW-2:0], st_w[j][RW+2]};
    end
  end

  assign root = root_r[RW-1];

endmodule

`default_nettype wire

// ===== hdl/depth_pixel_to_point_unit.sv =====
// Top level: turns a depth pixel into an undistorted 3D point in sensor axes.
// One transaction is accepted every cycle; busy stays low and the receiver cannot stall.
// The latency comes from the pipelined dividers and square root, one bit per stage.
// Side data rides in two delay RAMs addressed by a free-running pointer.
// Synchronous reset loads the register defaults and clears the valid pipeline.
`default_nettype none

module depth_pixel_to_point_unit import dpp_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [9:0]            in_pixel_row,
  input  wire logic [9:0]            in_pixel_col,
  input  wire logic [15:0]           in_depth,
  output logic                       out_valid,
  output logic signed [16:0]         out_point_x,
  output logic signed [16:0]         out_point_y,
  output logic signed [16:0]         out_point_z,
  output logic                       out_in_range,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int K_SQ_END = 1 + (RAY_QW + 1) + 1 + MUL_STAGES + SQRT_RW - 1;
  localparam int K_P13    = 1 + (RAY_QW + 1) + 1 + 12;
  localparam int D0       = K_SQ_END;
  localparam int D1       = K_SQ_END - K_P13;

  logic [31:0]        vert_focal_r, vert_center_r, horiz_focal_r, horiz_center_r;
  logic signed [31:0] k1_r, k2_r, k3_r;
  logic [63:0]        tang_r;
  logic signed [31:0] p1_w, p2_w;

  logic [LATENCY-1:0] vld_r;
  logic [DLY_AW-1:0]  cnt_r;

  logic signed [33:0] dra_w, drb_w;
  logic [32:0]        mra_w, mrb_w;
  logic [31:0]        fa_w, fb_w;
  logic               in_range_w;

  logic [RAY_NW-1:0]  ra_n_r, rb_n_r;
  logic [RAY_DW-1:0]  ra_f_r, rb_f_r;
  logic               ra_neg_r, rb_neg_r;
  logic [RAY_QW-1:0]  a_q_w, b_q_w;
  logic               a_ovf_w, b_ovf_w, a_neg_w, b_neg_w;
  logic signed [31:0] a_mag_w, b_mag_w;

  logic signed [31:0] a_dl_r [11];
  logic signed [31:0] b_dl_r [11];
  logic signed [63:0] aa_p_r, bb_p_r, ab_p_r;
  logic signed [31:0] a2_dl_r [2];
  logic signed [31:0] b2_dl_r [2];
  logic signed [31:0] ab_dl_r [9];
  logic signed [31:0] r2_dl_r [3];
  logic signed [31:0] ra_dl_r [7];
  logic signed [31:0] rb_dl_r [7];
  logic signed [63:0] r2r2_p_r, k1r2_p_r;
  logic signed [31:0] r4_r;
  logic signed [31:0] k1r2_dl_r [5];
  logic signed [63:0] r6_p_r, k2r4_p_r;
  logic signed [31:0] r6_r;
  logic signed [31:0] k2r4_dl_r [3];
  logic signed [63:0] k3r6_p_r;
  logic signed [31:0] k3r6_r;
  logic signed [31:0] g_r;
  logic signed [63:0] ag_p_r, bg_p_r, p1ab_p_r, p2ra_p_r, p1rb_p_r, p2ab_p_r;
  logic signed [31:0] ag_r, bg_r, p1ab_r, p2ra_r, p1rb_r, p2ab_r;
  logic signed [31:0] au_nxt, bu_nxt, au_r, bu_r;
  logic signed [63:0] au2_p_r, bu2_p_r;
  logic [63:0]        s_r;
  logic [SQRT_RW-1:0] n_w;

  logic [16:0]        side_w;
  logic [63:0]        ray_w;
  logic signed [31:0] au_w, bu_w;
  logic [30:0]        au_mag_w, bu_mag_w;

  logic [46:0]        px_p_r, py_p_r, pz_p_r;
  logic [SQRT_RW-1:0] n_p1_r;
  logic               ny_p1_r, nz_p1_r, inr_p1_r;
  logic [OUT_NW-1:0]  ox_n_r, oy_n_r, oz_n_r;
  logic [OUT_DW-1:0]  od_r;
  logic               ny_p2_r, nz_p2_r, inr_p2_r;
  logic [OUT_QW-1:0]  qx_w, qy_w, qz_w;
  logic               inr_q_w, ny_q_w, nz_q_w;

  logic signed [16:0] px_r, py_r, pz_r;
  logic               inr_r;

  assign busy = 1'b0;
  assign p1_w = $signed(tang_r[31:0]);
  assign p2_w = $signed(tang_r[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_focal_r   <= FOCAL_RESET;
      vert_center_r  <= '0;
      horiz_focal_r  <= FOCAL_RESET;
      horiz_center_r <= '0;
      k1_r           <= '0;
      k2_r           <= '0;
      k3_r           <= '0;
      tang_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERT_FOCAL:   vert_focal_r   <= cfg_wdata[31:0];
        REG_VERT_CENTER:  vert_center_r  <= cfg_wdata[31:0];
        REG_HORIZ_FOCAL:  horiz_focal_r  <= cfg_wdata[31:0];
        REG_HORIZ_CENTER: horiz_center_r <= cfg_wdata[31:0];
        REG_RADIAL_K1:    k1_r           <= $signed(cfg_wdata[31:0]);
        REG_RADIAL_K2:    k2_r           <= $signed(cfg_wdata[31:0]);
        REG_RADIAL_K3:    k3_r           <= $signed(cfg_wdata[31:0]);
        REG_TANGENTIAL:   tang_r         <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start & ~busy};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign dra_w = $signed({8'b0, in_pixel_row, 16'b0}) - $signed({2'b0, vert_center_r});
  assign drb_w = $signed({8'b0, in_pixel_col, 16'b0}) - $signed({2'b0, horiz_center_r});
  assign mra_w = dra_w[33] ? 33'(-dra_w) : dra_w[32:0];
  assign mrb_w = drb_w[33] ? 33'(-drb_w) : drb_w[32:0];
  assign fa_w  = (vert_focal_r == '0) ? 32'd1 : vert_focal_r;
  assign fb_w  = (horiz_focal_r == '0) ? 32'd1 : horiz_focal_r;
  assign in_range_w = ({1'b0, in_pixel_row} < 11'(IMAGE_HEIGHT)) &&
                      ({1'b0, in_pixel_col} < 11'(IMAGE_WIDTH));

  always_ff @(posedge clk) begin
    ra_n_r   <= {1'b0, mra_w, 28'b0} + RAY_NW'(fa_w[31:1]);
    rb_n_r   <= {1'b0, mrb_w, 28'b0} + RAY_NW'(fb_w[31:1]);
    ra_f_r   <= fa_w;
    rb_f_r   <= fb_w;
    ra_neg_r <= dra_w[33];
    rb_neg_r <= drb_w[33];
  end

  dpp_div #(.NW(RAY_NW), .DW(RAY_DW), .QW(RAY_QW), .TW(1)) u_div_a (
    .clk(clk), .n_in(ra_n_r), .d_in(ra_f_r), .tag_in(ra_neg_r),
    .q_out(a_q_w), .ovf_out(a_ovf_w), .tag_out(a_neg_w)
  );

  dpp_div #(.NW(RAY_NW), .DW(RAY_DW), .QW(RAY_QW), .TW(1)) u_div_b (
    .clk(clk), .n_in(rb_n_r), .d_in(rb_f_r), .tag_in(rb_neg_r),
    .q_out(b_q_w), .ovf_out(b_ovf_w), .tag_out(b_neg_w)
  );

  assign a_mag_w = a_ovf_w ? LIM28 : $signed({1'b0, a_q_w});
  assign b_mag_w = b_ovf_w ? LIM28 : $signed({1'b0, b_q_w});

  assign au_nxt = sat28(36'(ag_r) + 36'(p1ab_r) + 36'(p1ab_r) + 36'(p2ra_r));
  assign bu_nxt = sat28(36'(bg_r) + 36'(p1rb_r) + 36'(p2ab_r) + 36'(p2ab_r));

  always_ff @(posedge clk) begin
    a_dl_r[0] <= a_neg_w ? -a_mag_w : a_mag_w;
    b_dl_r[0] <= b_neg_w ? -b_mag_w : b_mag_w;
    for (int i = 1; i < 11; i++) begin
      a_dl_r[i] <= a_dl_r[i-1];
      b_dl_r[i] <= b_dl_r[i-1];
    end
    aa_p_r <= a_dl_r[0] * a_dl_r[0];
    bb_p_r <= b_dl_r[0] * b_dl_r[0];
    ab_p_r <= a_dl_r[0] * b_dl_r[0];
    a2_dl_r[0] <= rs28(aa_p_r);
    b2_dl_r[0] <= rs28(bb_p_r);
    a2_dl_r[1] <= a2_dl_r[0];
    b2_dl_r[1] <= b2_dl_r[0];
    ab_dl_r[0] <= rs28(ab_p_r);
    for (int i = 1; i < 9; i++) begin
      ab_dl_r[i] <= ab_dl_r[i-1];
    end
    r2_dl_r[0] <= sat28(36'(a2_dl_r[0]) + 36'(b2_dl_r[0]));
    r2_dl_r[1] <= r2_dl_r[0];
    r2_dl_r[2] <= r2_dl_r[1];
    r2r2_p_r <= r2_dl_r[0] * r2_dl_r[0];
    k1r2_p_r <= k1_r * r2_dl_r[0];
    ra_dl_r[0] <= sat28(36'(r2_dl_r[0]) + 36'(a2_dl_r[1]) + 36'(a2_dl_r[1]));
    rb_dl_r[0] <= sat28(36'(r2_dl_r[0]) + 36'(b2_dl_r[1]) + 36'(b2_dl_r[1]));
    for (int i = 1; i < 7; i++) begin
      ra_dl_r[i] <= ra_dl_r[i-1];
      rb_dl_r[i] <= rb_dl_r[i-1];
    end
    r4_r <= rs28(r2r2_p_r);
    k1r2_dl_r[0] <= rs28(k1r2_p_r);
    for (int i = 1; i < 5; i++) begin
      k1r2_dl_r[i] <= k1r2_dl_r[i-1];
    end
    r6_p_r   <= r2_dl_r[2] * r4_r;
    k2r4_p_r <= k2_r * r4_r;
    r6_r <= rs28(r6_p_r);
    k2r4_dl_r[0] <= rs28(k2r4_p_r);
    k2r4_dl_r[1] <= k2r4_dl_r[0];
    k2r4_dl_r[2] <= k2r4_dl_r[1];
    k3r6_p_r <= k3_r * r6_r;
    k3r6_r <= rs28(k3r6_p_r);
    g_r <= sat28(36'(ONE28) + 36'(k1r2_dl_r[4]) + 36'(k2r4_dl_r[2]) + 36'(k3r6_r));
    ag_p_r   <= a_dl_r[10] * g_r;
    bg_p_r   <= b_dl_r[10] * g_r;
    p1ab_p_r <= p1_w * ab_dl_r[8];
    p2ra_p_r <= p2_w * ra_dl_r[6];
    p1rb_p_r <= p1_w * rb_dl_r[6];
    p2ab_p_r <= p2_w * ab_dl_r[8];
    ag_r   <= rs28(ag_p_r);
    bg_r   <= rs28(bg_p_r);
    p1ab_r <= rs28(p1ab_p_r);
    p2ra_r <= rs28(p2ra_p_r);
    p1rb_r <= rs28(p1rb_p_r);
    p2ab_r <= rs28(p2ab_p_r);
    au_r <= au_nxt;
    bu_r <= bu_nxt;
    au2_p_r <= au_r * au_r;
    bu2_p_r <= bu_r * bu_r;
    s_r <= 64'(au2_p_r) + 64'(bu2_p_r) + 64'h0100_0000_0000_0000;
  end

  dpp_sqrt #(.RW(SQRT_RW)) u_sqrt (
    .clk(clk), .s_in(s_r), .root(n_w)
  );

  dpp_ram #(.WIDTH(17), .DEPTH(2 ** DLY_AW)) u_side_ram (
    .clk(clk), .wr_en(1'b1), .wr_addr(cnt_r), .wr_data({in_range_w, in_depth}),
    .rd_addr(cnt_r - DLY_AW'(D0)), .rd_data(side_w)
  );

  dpp_ram #(.WIDTH(64), .DEPTH(2 ** DLY_AW)) u_ray_ram (
    .clk(clk), .wr_en(1'b1), .wr_addr(cnt_r), .wr_data({au_nxt, bu_nxt}),
    .rd_addr(cnt_r - DLY_AW'(D1)), .rd_data(ray_w)
  );

  assign au_w     = $signed(ray_w[63:32]);
  assign bu_w     = $signed(ray_w[31:0]);
  assign au_mag_w = au_w[31] ? 31'(-au_w) : au_w[30:0];
  assign bu_mag_w = bu_w[31] ? 31'(-bu_w) : bu_w[30:0];

  always_ff @(posedge clk) begin
    px_p_r   <= 47'({side_w[15:0], 28'b0});
    py_p_r   <= side_w[15:0] * bu_mag_w;
    pz_p_r   <= side_w[15:0] * au_mag_w;
    n_p1_r   <= n_w;
    ny_p1_r  <= !bu_w[31] && (bu_w != '0);
    nz_p1_r  <= !au_w[31] && (au_w != '0);
    inr_p1_r <= side_w[16];
    ox_n_r   <= {2'b0, px_p_r, 1'b0} + OUT_NW'(n_p1_r);
    oy_n_r   <= {2'b0, py_p_r, 1'b0} + OUT_NW'(n_p1_r);
    oz_n_r   <= {2'b0, pz_p_r, 1'b0} + OUT_NW'(n_p1_r);
    od_r     <= {n_p1_r, 1'b0};
    ny_p2_r  <= ny_p1_r;
    nz_p2_r  <= nz_p1_r;
    inr_p2_r <= inr_p1_r;
  end

  dpp_div #(.NW(OUT_NW), .DW(OUT_DW), .QW(OUT_QW), .TW(1)) u_div_x (
    .clk(clk), .n_in(ox_n_r), .d_in(od_r), .tag_in(inr_p2_r),
    .q_out(qx_w), .ovf_out(), .tag_out(inr_q_w)
  );

  dpp_div #(.NW(OUT_NW), .DW(OUT_DW), .QW(OUT_QW), .TW(1)) u_div_y (
    .clk(clk), .n_in(oy_n_r), .d_in(od_r), .tag_in(ny_p2_r),
    .q_out(qy_w), .ovf_out(), .tag_out(ny_q_w)
  );

  dpp_div #(.NW(OUT_NW), .DW(OUT_DW), .QW(OUT_QW), .TW(1)) u_div_z (
    .clk(clk), .n_in(oz_n_r), .d_in(od_r), .tag_in(nz_p2_r),
    .q_out(qz_w), .ovf_out(), .tag_out(nz_q_w)
  );

  always_ff @(posedge clk) begin
    inr_r <= inr_q_w;
    if (inr_q_w) begin
      px_r <= $signed(qx_w);
      py_r <= ny_q_w ? -$signed(qy_w) : $signed(qy_w);
      pz_r <= nz_q_w ? -$signed(qz_w) : $signed(qz_w);
    end else begin
      px_r <= -17'sd1;
      py_r <= -17'sd1;
      pz_r <= -17'sd1;
    end
  end

  assign out_valid    = vld_r[LATENCY-1];
  assign out_point_x  = px_r;
  assign out_point_y  = py_r;
  assign out_point_z  = pz_r;
  assign out_in_range = inr_r;

endmodule

`default_nettype wire

// ===== hdl/dpp_checker.sv =====
// Port-level assertions for the depth pixel to point unit, bound to the top level.
`default_nettype none

module dpp_checker import dpp_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [9:0]            in_pixel_row,
  input wire logic [9:0]            in_pixel_col,
  input wire logic [15:0]           in_depth,
  input wire logic                  out_valid,
  input wire logic signed [16:0]    out_point_x,
  input wire logic signed [16:0]    out_point_y,
  input wire logic signed [16:0]    out_point_z,
  input wire logic                  out_in_range,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("An accepted transaction produced no result at the expected cycle.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("A result appeared without a matching accepted transaction.");

  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_in_range == $past(({1'b0, in_pixel_row} < 11'(IMAGE_HEIGHT)) &&
                                        ({1'b0, in_pixel_col} < 11'(IMAGE_WIDTH)), LATENCY))
    else $error("The in-range flag does not match the pixel position.");

  a_outside_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_point_x == 17'h1FFFF) && (out_point_y == 17'h1FFFF) && (out_point_z == 17'h1FFFF))
    else $error("A pixel outside the imager did not give the marker point.");

  a_forward_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |->
      (!out_point_x[16] && (out_point_x[15:0] <= $past(in_depth, LATENCY))))
    else $error("The forward coordinate lies outside zero to depth.");

  cfg_unused_c: cover property (@(posedge clk) cfg_we && (cfg_index == REG_TANGENTIAL) &&
                                (cfg_wdata != '0));

endmodule

bind depth_pixel_to_point_unit dpp_checker #(
  .IMAGE_WIDTH(IMAGE_WIDTH),
  .IMAGE_HEIGHT(IMAGE_HEIGHT)
) u_dpp_checker (.*);

`default_nettype wire
